// ----- design/assert_macros.svh -----
// Assertion macros for the depth-to-color remap block.
// Expects clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Single property, checked while out of reset.
`define DCR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Same-cycle implication, checked while out of reset.
`define DCR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- design/dcremap_pkg.sv -----
// Types and constants for the depth-to-color remap block.
// No dependencies; used by dcremap_cfg, dcremap_core and the top level.
`default_nettype none

package dcremap_pkg;

  localparam int COL_W     = 10;
  localparam int ROW_W     = 9;
  localparam int DMM_W     = 16;
  localparam int CFG_W     = 16;
  localparam int IDX_W     = 19;
  localparam int YPROD_W   = ROW_W + CFG_W;
  localparam int YQ_W      = YPROD_W + 2;
  localparam int YC_W      = YQ_W - 16;
  localparam int SLOPE_W   = 12;
  localparam int SPROD_W   = SLOPE_W + DMM_W;
  localparam int CX_W      = SPROD_W + 2;
  localparam int SCALE2_W  = CFG_W + 2;

  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_SCALE_X   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_SCALE_Y   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_OFFSET_Y  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_MIN_DEPTH = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_MAX_DEPTH = 3'd4;

  localparam logic [CFG_W-1:0] RST_SCALE_X   = 16'd29065;
  localparam logic [CFG_W-1:0] RST_SCALE_Y   = 16'd28957;
  localparam logic [CFG_W-1:0] RST_OFFSET_Y  = 16'd4608;
  localparam logic [CFG_W-1:0] RST_MIN_DEPTH = 16'd500;
  localparam logic [CFG_W-1:0] RST_MAX_DEPTH = 16'd2000;

  localparam int SEG_W = 3;
  localparam logic [SEG_W-1:0] SEG_LOW   = 3'd0;
  localparam logic [SEG_W-1:0] SEG_ONE   = 3'd1;
  localparam logic [SEG_W-1:0] SEG_TWO   = 3'd2;
  localparam logic [SEG_W-1:0] SEG_THREE = 3'd3;
  localparam logic [SEG_W-1:0] SEG_HIGH  = 3'd4;

  localparam logic [DMM_W-1:0] DEPTH_SEG1_LO = 16'd550;
  localparam logic [DMM_W-1:0] DEPTH_SEG1_HI = 16'd780;
  localparam logic [DMM_W-1:0] DEPTH_SEG2_HI = 16'd1020;
  localparam logic [DMM_W-1:0] DEPTH_SEG3_HI = 16'd1724;

  localparam logic [SLOPE_W-1:0] SLOPE_ONE   = 12'd2849;
  localparam logic [SLOPE_W-1:0] SLOPE_TWO   = 12'd1092;
  localparam logic [SLOPE_W-1:0] SLOPE_THREE = 12'd279;

  localparam logic signed [CX_W-1:0] ICPT_ONE   = -30'sd780730;
  localparam logic signed [CX_W-1:0] ICPT_TWO   = 30'sd589804;
  localparam logic signed [CX_W-1:0] ICPT_THREE = 30'sd1419051;
  localparam logic signed [CX_W-1:0] FLAT_LOW   = 30'sd786432;
  localparam logic signed [CX_W-1:0] FLAT_HIGH  = 30'sd1900544;

  typedef struct packed {
    logic [CFG_W-1:0] scale_x;
    logic [CFG_W-1:0] scale_y;
    logic [CFG_W-1:0] offset_y;
    logic [CFG_W-1:0] min_depth;
    logic [CFG_W-1:0] max_depth;
  } cfg_t;

endpackage

`default_nettype wire

// ----- design/dcremap_cfg.sv -----
// APB-style register file for the remap block: scale, offset and depth window.
// Depends on dcremap_pkg.
`default_nettype none

module dcremap_cfg
  import dcremap_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready,
  output cfg_t                       cfg
);

  cfg_t                 cfg_r;
  cfg_t                 cfg_nxt;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;
  logic [CFG_W-1:0]     wr_val;

  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign wr_val  = pwdata[CFG_W-1:0];

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        REG_SCALE_X:   cfg_nxt.scale_x   = wr_val;
        REG_SCALE_Y:   cfg_nxt.scale_y   = wr_val;
        REG_OFFSET_Y:  cfg_nxt.offset_y  = wr_val;
        REG_MIN_DEPTH: cfg_nxt.min_depth = wr_val;
        REG_MAX_DEPTH: cfg_nxt.max_depth = wr_val;
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.scale_x   <= RST_SCALE_X;
      cfg_r.scale_y   <= RST_SCALE_Y;
      cfg_r.offset_y  <= RST_OFFSET_Y;
      cfg_r.min_depth <= RST_MIN_DEPTH;
      cfg_r.max_depth <= RST_MAX_DEPTH;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SCALE_X:   prdata = APB_DATA_W'(cfg_r.scale_x);
      REG_SCALE_Y:   prdata = APB_DATA_W'(cfg_r.scale_y);
      REG_OFFSET_Y:  prdata = APB_DATA_W'(cfg_r.offset_y);
      REG_MIN_DEPTH: prdata = APB_DATA_W'(cfg_r.min_depth);
      REG_MAX_DEPTH: prdata = APB_DATA_W'(cfg_r.max_depth);
      default:       prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ----- design/dcremap_core.sv -----
// Five-stage remap datapath: depth offset, scaling, floor, frame check, index.
// Depends on dcremap_pkg; configuration comes from dcremap_cfg.
`default_nettype none

module dcremap_core
  import dcremap_pkg::*;
#(
  parameter int FRAME_WIDTH  = 640,
  parameter int FRAME_HEIGHT = 480
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  cfg_t                  cfg,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [COL_W-1:0] in_depth_col,
  input  wire logic [ROW_W-1:0] in_depth_row,
  input  wire logic [DMM_W-1:0] in_depth_mm,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic                  out_mapped,
  output logic      [COL_W-1:0] out_color_col,
  output logic      [ROW_W-1:0] out_color_row,
  output logic      [IDX_W-1:0] out_color_index,
  output logic      [COL_W-1:0] out_src_col,
  output logic      [ROW_W-1:0] out_src_row
);

  localparam int FW_BITS  = $clog2(FRAME_WIDTH + 1);
  localparam int FH_BITS  = $clog2(FRAME_HEIGHT + 1);
  localparam int DIFF_W   = ((FW_BITS > COL_W) ? FW_BITS : COL_W) + 1;
  localparam int XPROD_W  = DIFF_W + SCALE2_W;
  localparam int XQ_W     = ((XPROD_W + 1 > CX_W) ? XPROD_W + 1 : CX_W) + 1;
  localparam int XC_W     = XQ_W - 16;
  localparam int YCMP_W   = (FH_BITS > YC_W) ? FH_BITS : YC_W;
  localparam int XCU_W    = $clog2(FRAME_WIDTH);
  localparam int YCU_W    = $clog2(FRAME_HEIGHT);
  localparam int IDXF_W   = YCU_W + FW_BITS + 1;

  // stage enables, last to first
  logic en1, en2, en3, en4, en5;
  logic vld1_r, vld2_r, vld3_r, vld4_r, vld5_r;

  assign en5      = !vld5_r || out_ready;
  assign en4      = !vld4_r || en5;
  assign en3      = !vld3_r || en4;
  assign en2      = !vld2_r || en3;
  assign en1      = !vld1_r || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
      vld5_r <= 1'b0;
    end else begin
      if (en1) vld1_r <= in_valid;
      if (en2) vld2_r <= vld1_r;
      if (en3) vld3_r <= vld2_r;
      if (en4) vld4_r <= vld3_r;
      if (en5) vld5_r <= vld4_r;
    end
  end

  // stage 1: segment, window, mirror, row product
  logic [COL_W-1:0]          col1_r, col1_nxt;
  logic [ROW_W-1:0]          row1_r, row1_nxt;
  logic [DMM_W-1:0]          dmm1_r, dmm1_nxt;
  logic [SEG_W-1:0]          seg1_r, seg1_nxt;
  logic                      win1_r, win1_nxt;
  logic signed [DIFF_W-1:0]  diff1_r, diff1_nxt;
  logic [YPROD_W-1:0]        yprod1_r, yprod1_nxt;

  always_comb begin
    col1_nxt = in_depth_col;
    row1_nxt = in_depth_row;
    dmm1_nxt = in_depth_mm;
    if (in_depth_mm < DEPTH_SEG1_LO) begin
      seg1_nxt = SEG_LOW;
    end else if (in_depth_mm <= DEPTH_SEG1_HI) begin
      seg1_nxt = SEG_ONE;
    end else if (in_depth_mm <= DEPTH_SEG2_HI) begin
      seg1_nxt = SEG_TWO;
    end else if (in_depth_mm <= DEPTH_SEG3_HI) begin
      seg1_nxt = SEG_THREE;
    end else begin
      seg1_nxt = SEG_HIGH;
    end
    win1_nxt   = (in_depth_mm >= cfg.min_depth) && (in_depth_mm <= cfg.max_depth);
    diff1_nxt  = $signed(DIFF_W'(FRAME_WIDTH) - DIFF_W'(in_depth_col));
    yprod1_nxt = YPROD_W'(in_depth_row) * YPROD_W'(cfg.scale_y);
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      col1_r   <= col1_nxt;
      row1_r   <= row1_nxt;
      dmm1_r   <= dmm1_nxt;
      seg1_r   <= seg1_nxt;
      win1_r   <= win1_nxt;
      diff1_r  <= diff1_nxt;
      yprod1_r <= yprod1_nxt;
    end
  end

  // stage 2: segment product, column product, row sum
  logic [COL_W-1:0]           col2_r;
  logic [ROW_W-1:0]           row2_r;
  logic [SEG_W-1:0]           seg2_r;
  logic                       win2_r;
  logic [SLOPE_W-1:0]         slope;
  logic [SPROD_W-1:0]         sprod2_r, sprod2_nxt;
  logic signed [SCALE2_W-1:0] scale2;
  logic signed [XPROD_W-1:0]  xprod2_r, xprod2_nxt;
  logic [YQ_W-1:0]            yq2_r, yq2_nxt;

  always_comb begin
    case (seg1_r)
      SEG_ONE:   slope = SLOPE_ONE;
      SEG_TWO:   slope = SLOPE_TWO;
      SEG_THREE: slope = SLOPE_THREE;
      default:   slope = '0;
    endcase
    sprod2_nxt = SPROD_W'(slope) * SPROD_W'(dmm1_r);
    scale2     = $signed({1'b0, cfg.scale_x, 1'b0});
    xprod2_nxt = XPROD_W'(diff1_r) * XPROD_W'(scale2);
    yq2_nxt    = YQ_W'({yprod1_r, 1'b0}) + YQ_W'({cfg.offset_y, 8'b0});
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      col2_r   <= col1_r;
      row2_r   <= row1_r;
      seg2_r   <= seg1_r;
      win2_r   <= win1_r;
      sprod2_r <= sprod2_nxt;
      xprod2_r <= xprod2_nxt;
      yq2_r    <= yq2_nxt;
    end
  end

  // stage 3: depth offset, row floor
  logic [COL_W-1:0]          col3_r;
  logic [ROW_W-1:0]          row3_r;
  logic                      win3_r;
  logic signed [CX_W-1:0]    sprod_s;
  logic signed [CX_W-1:0]    cx3_r, cx3_nxt;
  logic signed [XPROD_W-1:0] xprod3_r;
  logic [YC_W-1:0]           yc3_r;

  always_comb begin
    sprod_s = $signed(CX_W'(sprod2_r));
    case (seg2_r)
      SEG_LOW:   cx3_nxt = FLAT_LOW;
      SEG_ONE:   cx3_nxt = sprod_s + ICPT_ONE;
      SEG_TWO:   cx3_nxt = sprod_s + ICPT_TWO;
      SEG_THREE: cx3_nxt = sprod_s + ICPT_THREE;
      SEG_HIGH:  cx3_nxt = FLAT_HIGH;
      default:   cx3_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      col3_r   <= col2_r;
      row3_r   <= row2_r;
      win3_r   <= win2_r;
      cx3_r    <= cx3_nxt;
      xprod3_r <= xprod2_r;
      yc3_r    <= yq2_r[YQ_W-1:16];
    end
  end

  // stage 4: column sum, floor, frame check
  logic [COL_W-1:0]       col4_r;
  logic [ROW_W-1:0]       row4_r;
  logic signed [XQ_W-1:0] xq;
  logic signed [XC_W-1:0] xc;
  logic                   ok4_r, ok4_nxt;
  logic [XCU_W-1:0]       xc4_r;
  logic [YCU_W-1:0]       yc4_r;

  always_comb begin
    xq      = XQ_W'(xprod3_r) + XQ_W'(cx3_r);
    xc      = xq[XQ_W-1:16];
    ok4_nxt = win3_r && !xc[XC_W-1]
              && (xc[XC_W-2:0] < (XC_W-1)'(FRAME_WIDTH))
              && (YCMP_W'(yc3_r) < YCMP_W'(FRAME_HEIGHT));
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      col4_r <= col3_r;
      row4_r <= row3_r;
      ok4_r  <= ok4_nxt;
      xc4_r  <= xc[XCU_W-1:0];
      yc4_r  <= YCU_W'(yc3_r);
    end
  end

  // stage 5: map address, output register
  logic [IDXF_W-1:0] idx_full;
  logic              mapped5_r;
  logic [COL_W-1:0]  ccol5_r, ccol5_nxt;
  logic [ROW_W-1:0]  crow5_r, crow5_nxt;
  logic [IDX_W-1:0]  cidx5_r, cidx5_nxt;
  logic [COL_W-1:0]  scol5_r;
  logic [ROW_W-1:0]  srow5_r;

  always_comb begin
    idx_full = IDXF_W'(yc4_r) * IDXF_W'(FRAME_WIDTH) + IDXF_W'(xc4_r);
    if (ok4_r) begin
      ccol5_nxt = COL_W'(xc4_r);
      crow5_nxt = ROW_W'(yc4_r);
      cidx5_nxt = IDX_W'(idx_full);
    end else begin
      ccol5_nxt = '0;
      crow5_nxt = '0;
      cidx5_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      mapped5_r <= ok4_r;
      ccol5_r   <= ccol5_nxt;
      crow5_r   <= crow5_nxt;
      cidx5_r   <= cidx5_nxt;
      scol5_r   <= col4_r;
      srow5_r   <= row4_r;
    end
  end

  assign out_valid       = vld5_r;
  assign out_mapped      = mapped5_r;
  assign out_color_col   = ccol5_r;
  assign out_color_row   = crow5_r;
  assign out_color_index = cidx5_r;
  assign out_src_col     = scol5_r;
  assign out_src_row     = srow5_r;

endmodule

`default_nettype wire

// ----- design/depth_to_color_pixel_remap.sv -----
// Top level of the depth-to-color pixel remap block.
// Depends on dcremap_pkg, dcremap_cfg, dcremap_core and assert_macros.svh.
//
//   channel | handshake          | beat
//   --------+--------------------+-----------------------------------------------
//   in      | in_valid/in_ready  | depth_col, depth_row, depth_mm
//   out     | out_valid/out_ready| mapped, color_col/row/index, src_col/row
//   cfg     | psel/penable/pready| 16-bit register write or read, addr 4*index
//
// One beat per clock in and out while out_ready holds.
// Five register stages, set by the multiplies and the wide column sum.
// Reset restores the config registers and empties the pipeline; no clearing pass.
// Each stage holds on its own; a bubble fills while the output stalls.
`default_nettype none

`include "assert_macros.svh"

module depth_to_color_pixel_remap
  import dcremap_pkg::*;
#(
  parameter int FRAME_WIDTH  = 640,
  parameter int FRAME_HEIGHT = 480
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [COL_W-1:0]      in_depth_col,
  input  wire logic [ROW_W-1:0]      in_depth_row,
  input  wire logic [DMM_W-1:0]      in_depth_mm,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       out_mapped,
  output logic      [COL_W-1:0]      out_color_col,
  output logic      [ROW_W-1:0]      out_color_row,
  output logic      [IDX_W-1:0]      out_color_index,
  output logic      [COL_W-1:0]      out_src_col,
  output logic      [ROW_W-1:0]      out_src_row,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready
);

  cfg_t cfg;

  dcremap_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dcremap_core #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT)
  ) u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_depth_col    (in_depth_col),
    .in_depth_row    (in_depth_row),
    .in_depth_mm     (in_depth_mm),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_mapped      (out_mapped),
    .out_color_col   (out_color_col),
    .out_color_row   (out_color_row),
    .out_color_index (out_color_index),
    .out_src_col     (out_src_col),
    .out_src_row     (out_src_row)
  );

  `DCR_ASSERT_IMPL(a_unmapped_zero, out_valid && !out_mapped, out_color_col == '0 && out_color_row == '0 && out_color_index == '0, "unmapped beat carries color fields")
  `DCR_ASSERT_IMPL(a_mapped_in_frame, out_valid && out_mapped, out_color_col < FRAME_WIDTH && out_color_row < FRAME_HEIGHT, "mapped beat outside the frame")
  `DCR_ASSERT(a_ready_when_drained, !out_valid |-> in_ready, "input stalled with empty output")

endmodule

`default_nettype wire

// ----- verif/depth_to_color_pixel_remap_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for depth_to_color_pixel_remap: predicts each color pixel
// in Q.16 fixed point and compares every output beat in order. Uses dcremap_pkg only.

module depth_to_color_pixel_remap_tb;
  import dcremap_pkg::*;

  localparam int FRAME_W = 640;
  localparam int FRAME_H = 480;

  typedef struct {
    logic             mapped;
    logic [COL_W-1:0] color_col;
    logic [ROW_W-1:0] color_row;
    logic [IDX_W-1:0] color_index;
    logic [COL_W-1:0] src_col;
    logic [ROW_W-1:0] src_row;
  } pixel_map_t;

  typedef enum int {DRAIN_FREE, DRAIN_COIN, DRAIN_MOSTLY, DRAIN_TRICKLE} drain_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [COL_W-1:0] in_depth_col = '0;
  logic [ROW_W-1:0] in_depth_row = '0;
  logic [DMM_W-1:0] in_depth_mm = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_mapped;
  logic [COL_W-1:0] out_color_col;
  logic [ROW_W-1:0] out_color_row;
  logic [IDX_W-1:0] out_color_index;
  logic [COL_W-1:0] out_src_col;
  logic [ROW_W-1:0] out_src_row;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  cfg_t remap_cfg;
  pixel_map_t pending_maps[$];
  pixel_map_t oldest_map;
  int mismatches = 0;
  int pixels_sent = 0;
  int maps_seen = 0;
  int mapped_seen = 0;
  int reg_writes = 0;
  int burst_left = 0;
  int drain_left = 0;
  int hold_left = 0;
  bit hold_req = 1'b0;
  drain_mode_t drain_mode = DRAIN_FREE;

  depth_to_color_pixel_remap uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_depth_col(in_depth_col),
    .in_depth_row(in_depth_row),
    .in_depth_mm(in_depth_mm),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_mapped(out_mapped),
    .out_color_col(out_color_col),
    .out_color_row(out_color_row),
    .out_color_index(out_color_index),
    .out_src_col(out_src_col),
    .out_src_row(out_src_row),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #5 clk = ~clk;

  // horizontal offset in Q.16 for a depth in mm
  function automatic longint depth_col_offset(logic [DMM_W-1:0] dmm);
    longint d;
    d = longint'(dmm);
    if (dmm < DEPTH_SEG1_LO) return longint'(FLAT_LOW);
    if (dmm <= DEPTH_SEG1_HI) return longint'(SLOPE_ONE) * d + longint'(ICPT_ONE);
    if (dmm <= DEPTH_SEG2_HI) return longint'(SLOPE_TWO) * d + longint'(ICPT_TWO);
    if (dmm <= DEPTH_SEG3_HI) return longint'(SLOPE_THREE) * d + longint'(ICPT_THREE);
    return longint'(FLAT_HIGH);
  endfunction

  function automatic pixel_map_t predict_color_pixel(logic [COL_W-1:0] col,
                                                     logic [ROW_W-1:0] row,
                                                     logic [DMM_W-1:0] dmm);
    longint xq, yq, xc, yc, addr;
    pixel_map_t r;
    xq = (longint'(FRAME_W) - longint'(col)) * longint'(remap_cfg.scale_x) * 2
         + depth_col_offset(dmm);
    yq = longint'(row) * longint'(remap_cfg.scale_y) * 2 + longint'(remap_cfg.offset_y) * 256;
    xc = xq >>> 16;
    yc = yq >>> 16;
    addr = yc * FRAME_W + xc;
    r.mapped = dmm >= remap_cfg.min_depth && dmm <= remap_cfg.max_depth
               && xc >= 0 && xc < FRAME_W && yc >= 0 && yc < FRAME_H;
    r.color_col = r.mapped ? xc[COL_W-1:0] : '0;
    r.color_row = r.mapped ? yc[ROW_W-1:0] : '0;
    r.color_index = r.mapped ? addr[IDX_W-1:0] : '0;
    r.src_col = col;
    r.src_row = row;
    return r;
  endfunction

  // write one register, then read it back in the next transfer
  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {16'h0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== {16'h0, val}) begin
      mismatches++;
      if (mismatches <= 10)
        $display("readback reg %0d: expected %h got %h", idx, val, prdata);
    end
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_SCALE_X:   remap_cfg.scale_x = val;
      REG_SCALE_Y:   remap_cfg.scale_y = val;
      REG_OFFSET_Y:  remap_cfg.offset_y = val;
      REG_MIN_DEPTH: remap_cfg.min_depth = val;
      REG_MAX_DEPTH: remap_cfg.max_depth = val;
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic load_cfg(logic [CFG_W-1:0] sx, logic [CFG_W-1:0] sy, logic [CFG_W-1:0] oy,
                          logic [CFG_W-1:0] lo, logic [CFG_W-1:0] hi);
    write_reg(REG_SCALE_X, sx);
    write_reg(REG_SCALE_Y, sy);
    write_reg(REG_OFFSET_Y, oy);
    write_reg(REG_MIN_DEPTH, lo);
    write_reg(REG_MAX_DEPTH, hi);
  endtask

  task automatic send_pixel(logic [COL_W-1:0] col, logic [ROW_W-1:0] row,
                            logic [DMM_W-1:0] dmm);
    in_valid <= 1'b1;
    in_depth_col <= col;
    in_depth_row <= row;
    in_depth_mm <= dmm;
    do @(posedge clk); while (!in_ready);
    pending_maps.insert(pending_maps.size(), predict_color_pixel(col, row, dmm));
    pixels_sent++;
  endtask

  // drop valid for a random gap, sometimes none, at the end of each burst
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_random_pixel(bit well_formed);
    int lo, hi, t;
    lo = int'(remap_cfg.min_depth) - 60;
    hi = int'(remap_cfg.max_depth) + 60;
    if (lo > hi) begin
      t = lo;
      lo = hi;
      hi = t;
    end
    if (lo < 0) lo = 0;
    if (hi > 65535) hi = 65535;
    if (well_formed)
      send_pixel(COL_W'($urandom_range(0, FRAME_W - 1)), ROW_W'($urandom_range(0, FRAME_H - 1)),
                 DMM_W'($urandom_range(lo, hi)));
    else
      send_pixel(COL_W'($urandom_range(0, 1023)), ROW_W'($urandom_range(0, 511)),
                 DMM_W'($urandom_range(0, 65535)));
    pace_sender();
  endtask

  // wait until every beat has drained, then let the clock idle before returning
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_maps.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic test_segment_edges();
    int depths[16] = '{0, 499, 500, 549, 550, 551, 780, 781, 1020, 1021, 1724, 1725,
                       2000, 2001, 32768, 65535};
    for (int i = 0; i < 16; i++)
      send_pixel(COL_W'((i % 2) ? FRAME_W - 1 : 0),
                 ROW_W'((i % 3 == 0) ? FRAME_H - 1 : i * 17), DMM_W'(depths[i]));
    send_pixel(COL_W'(FRAME_W), 100, 1000);
    send_pixel(1023, 511, 900);
    send_pixel(700, 0, 600);
    send_pixel(320, 511, 1200);
    send_pixel(512, 256, 1500);
    settle();
  endtask

  task automatic test_config_extremes();
    load_cfg(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF);
    send_pixel(COL_W'(FRAME_W - 1), 0, 0);
    send_pixel(COL_W'(FRAME_W - 1), 1, 65535);
    repeat (20) send_random_pixel($urandom_range(0, 3) != 0);
    settle();
    load_cfg(16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000);
    send_pixel(0, 0, 0);
    send_pixel(1023, 511, 0);
    send_pixel(10, 10, 1);
    repeat (20) send_random_pixel($urandom_range(0, 3) != 0);
    settle();
    load_cfg(16'd32768, 16'd32768, 16'h0000, 16'd2000, 16'd1000);
    send_pixel(100, 100, 1500);
    repeat (20) send_random_pixel($urandom_range(0, 3) != 0);
    settle();
    load_cfg(16'd32768, 16'd16384, 16'd256, 16'd550, 16'd1724);
    send_pixel(0, ROW_W'(FRAME_H - 1), 550);
    send_pixel(1, ROW_W'(FRAME_H - 1), 1724);
    repeat (30) send_random_pixel($urandom_range(0, 3) != 0);
    settle();
  endtask

  task automatic test_random_stream();
    load_cfg(RST_SCALE_X, RST_SCALE_Y, RST_OFFSET_Y, RST_MIN_DEPTH, RST_MAX_DEPTH);
    repeat (360) send_random_pixel($urandom_range(0, 4) != 0);
    settle();
  endtask

  // long output hold while the sender keeps offering beats back to back
  task automatic test_output_hold();
    hold_req = 1'b1;
    repeat (40)
      send_pixel(COL_W'($urandom_range(0, FRAME_W - 1)), ROW_W'($urandom_range(0, FRAME_H - 1)),
                 DMM_W'($urandom_range(400, 2100)));
    settle();
  endtask

  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = 150;
      hold_req = 1'b0;
    end
    if (drain_left == 0) begin
      drain_mode = drain_mode_t'($urandom_range(0, 3));
      drain_left = $urandom_range(8, 64);
    end else begin
      drain_left--;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      case (drain_mode)
        DRAIN_FREE:   out_ready <= 1'b1;
        DRAIN_COIN:   out_ready <= ($urandom_range(0, 1) == 1);
        DRAIN_MOSTLY: out_ready <= ($urandom_range(0, 7) != 0);
        default:      out_ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      maps_seen++;
      if (pending_maps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected beat: src %0d,%0d", out_src_col, out_src_row);
      end else begin
        oldest_map = pending_maps.pop_front();
        if (out_mapped) mapped_seen++;
        if (out_mapped !== oldest_map.mapped || out_color_col !== oldest_map.color_col
            || out_color_row !== oldest_map.color_row
            || out_color_index !== oldest_map.color_index
            || out_src_col !== oldest_map.src_col || out_src_row !== oldest_map.src_row) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("beat %0d: expected m=%0d c=%0d r=%0d i=%0d s=%0d,%0d",
                     maps_seen, oldest_map.mapped, oldest_map.color_col, oldest_map.color_row,
                     oldest_map.color_index, oldest_map.src_col, oldest_map.src_row);
            $display("  got m=%0d c=%0d r=%0d i=%0d s=%0d,%0d",
                     out_mapped, out_color_col, out_color_row, out_color_index,
                     out_src_col, out_src_row);
          end
        end
      end
    end
  end

  initial begin
    remap_cfg.scale_x = RST_SCALE_X;
    remap_cfg.scale_y = RST_SCALE_Y;
    remap_cfg.offset_y = RST_OFFSET_Y;
    remap_cfg.min_depth = RST_MIN_DEPTH;
    remap_cfg.max_depth = RST_MAX_DEPTH;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_segment_edges();
    test_config_extremes();
    test_output_hold();
    test_random_stream();
    if (pending_maps.size() != 0) mismatches++;
    $display("sent %0d depth pixels over %0d register writes; %0d beats checked, %0d mapped",
             pixels_sent, reg_writes, maps_seen, mapped_seen);
    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d beats outstanding", pending_maps.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
